FILE: rtl/tclp_pkg.sv
`default_nettype none
package tclp_pkg;
  localparam int MaxMotorsDef = 8;
  localparam int LineLimitDef = 1024;
  localparam logic [9:0] ThrottleFull = 10'd1000;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_TICK   = 2'd1,
    OP_FAULT  = 2'd2,
    OP_CLOSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_MOTORS  = 2'd0,
    CFG_TIMEOUT = 2'd1,
    CFG_SAFE    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_RUN  = 2'd0,
    MODE_SHUT = 2'd1,
    MODE_LAND = 2'd2
  } mode_t;

  typedef enum logic [4:0] {
    PH_START, PH_H, PH_HB, PH_M, PH_S, PH_ST, PH_STA, PH_STO, PH_F, PH_FI,
    PH_L, PH_LA, PH_LAN, PH_P, PH_PI, PH_PIN, PH_I, PH_IN, PH_INF, PH_NUM,
    PH_MT_DONE, PH_STAN, PH_FIN, PH_LAND, PH_INFO, PH_PING_DONE, PH_BAD
  } phase_t;

  typedef enum logic [1:0] {
    SUB_SKIP   = 2'd0,
    SUB_SIGN   = 2'd1,
    SUB_DIGITS = 2'd2
  } sub_t;

  typedef enum logic [1:0] {
    NK_COUNT = 2'd0,
    NK_VALUE = 2'd1,
    NK_PING  = 2'd2
  } nkind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRAME,
    ST_PONG
  } ctl_state_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic frame_step;
    logic frame_start;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic want_frame;
    logic want_pong;
    logic frame_last;
    logic halted;
  } ctl_stat_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) ||
           (c == 8'h0D);
  endfunction
endpackage
`default_nettype wire

FILE: rtl/tclp_ctrl.sv
`default_nettype none
module tclp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire tclp_pkg::ctl_stat_t stat,
  output tclp_pkg::ctl_cmd_t      cmd,
  output logic                    out_is_pong
);
  import tclp_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !stat.halted) begin
          if (stat.want_pong) begin
            state_next = ST_PONG;
          end else if (stat.want_frame) begin
            state_next = ST_FRAME;
          end
        end
      end
      ST_FRAME: begin
        if (out_ready && stat.frame_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_PONG: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    out_is_pong     = 1'b0;
    cmd.accept      = 1'b0;
    cmd.frame_step  = 1'b0;
    cmd.frame_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.accept      = in_valid;
        cmd.frame_start = in_valid;
      end
      ST_FRAME: begin
        out_valid      = 1'b1;
        cmd.frame_step = out_ready;
      end
      ST_PONG: begin
        out_valid   = 1'b1;
        out_is_pong = 1'b1;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/tclp_dp.sv
`default_nettype none
module tclp_dp #(
  parameter int MAX_MOTORS = tclp_pkg::MaxMotorsDef,
  parameter int LINE_LIMIT = tclp_pkg::LineLimitDef
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [1:0]         operation,
  input  wire logic [7:0]         byte_value,
  input  wire logic               cfg_valid,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  input  wire tclp_pkg::ctl_cmd_t cmd,
  input  wire logic               out_is_pong,
  output tclp_pkg::ctl_stat_t     stat,
  output logic                    kind,
  output logic [2:0]              motor_index,
  output logic [9:0]              throttle,
  output logic                    last,
  output logic [63:0]             pong_value,
  output logic [1:0]              mode,
  output logic                    standby
);
  import tclp_pkg::*;

  localparam int LenW = $clog2(LINE_LIMIT);
  localparam int CurW = $clog2(MAX_MOTORS + 1) < 4 ? 4 : $clog2(MAX_MOTORS + 1);
  localparam int IdxW = MAX_MOTORS > 1 ? $clog2(MAX_MOTORS) : 1;
  localparam logic [63:0] MagLimit = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Int64Top = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Div10Lim = 64'd922337203685477580;

  logic [3:0]  motor_count;
  logic [23:0] timeout_ticks;
  logic [9:0]  safe_land_throttle;

  logic        standby_flag, standby_flag_next;
  mode_t       run_mode, run_mode_next;
  phase_t      parse_phase, parse_phase_next;
  sub_t        num_sub, num_sub_next;
  nkind_t      num_kind, num_kind_next;
  logic [LenW-1:0] line_length, line_length_next;
  logic [23:0] idle_ticks, idle_ticks_next;
  logic [63:0] acc, acc_next;
  logic        neg, neg_next;
  logic [CurW-1:0] cursor, cursor_next;
  logic [9:0]  pending [MAX_MOTORS];
  logic [9:0]  current [MAX_MOTORS];
  logic        wr_pend;
  logic [IdxW-1:0] wr_pend_idx;
  logic [9:0]  wr_pend_val;
  logic        set_cur_pend, set_cur_safe, clr_cur;
  logic        want_frame, want_pong;
  logic [CurW-1:0] eff_n;
  logic [IdxW-1:0] fidx;
  logic [9:0]  safe_sat;

  assign eff_n = ({{(CurW-4){1'b0}}, motor_count} > CurW'(MAX_MOTORS)) ?
                 CurW'(MAX_MOTORS) : CurW'({{(CurW-4){1'b0}}, motor_count});
  assign safe_sat = (safe_land_throttle > ThrottleFull) ? ThrottleFull :
                    safe_land_throttle;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_count        <= 4'd4;
      timeout_ticks      <= 24'd200;
      safe_land_throttle <= 10'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MOTORS:  motor_count        <= cfg_data[3:0];
        CFG_TIMEOUT: timeout_ticks      <= cfg_data;
        CFG_SAFE:    safe_land_throttle <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Per-item update of the parser state.
  always_comb begin
    logic [7:0]  c;
    logic        digit, fin_num, done;
    logic [63:0] d;
    logic [63:0] pv;
    logic [CurW-1:0] cur1;
    phase_t      ph;
    c = byte_value;
    d = {60'd0, c[3:0]};
    digit = (c >= 8'h30) && (c <= 8'h39);
    done = 1'b0;
    fin_num = 1'b0;
    cur1 = cursor + CurW'(1);
    pv = 64'd0;
    ph = PH_START;
    standby_flag_next = standby_flag;
    run_mode_next     = run_mode;
    parse_phase_next  = parse_phase;
    num_sub_next      = num_sub;
    num_kind_next     = num_kind;
    line_length_next  = line_length;
    idle_ticks_next   = idle_ticks;
    acc_next          = acc;
    neg_next          = neg;
    cursor_next       = cursor;
    wr_pend = 1'b0;
    wr_pend_idx = cursor[IdxW-1:0];
    wr_pend_val = acc[9:0];
    set_cur_pend = 1'b0;
    set_cur_safe = 1'b0;
    clr_cur = 1'b0;
    want_frame = 1'b0;
    want_pong = 1'b0;

    if (run_mode == MODE_RUN) begin
      case (operation)
        OP_TICK: begin
          if (standby_flag) begin
            idle_ticks_next = 24'd0;
          end else begin
            if (idle_ticks != 24'hFFFFFF) idle_ticks_next = idle_ticks + 24'd1;
            if (idle_ticks_next >= timeout_ticks) begin
              run_mode_next = MODE_LAND;
              set_cur_safe = 1'b1;
              want_frame = 1'b1;
            end
          end
        end
        OP_FAULT: begin
          run_mode_next = MODE_LAND;
          set_cur_safe = 1'b1;
          want_frame = 1'b1;
        end
        OP_CLOSED: begin
          if (!standby_flag) begin
            run_mode_next = MODE_LAND;
            set_cur_safe = 1'b1;
            want_frame = 1'b1;
          end
        end
        default: begin
          idle_ticks_next = 24'd0;
          if (line_length >= LenW'(LINE_LIMIT - 2)) begin
            run_mode_next = MODE_LAND;
            set_cur_safe = 1'b1;
            want_frame = 1'b1;
          end else if (c == 8'h0A) begin
            line_length_next = '0;
            ph = parse_phase;
            if (parse_phase == PH_NUM && num_sub == SUB_DIGITS) fin_num = 1'b1;
            if (parse_phase == PH_NUM && num_kind == NK_PING) ph = PH_PING_DONE;
            if (fin_num) begin
              if (num_kind == NK_PING) begin
                ph = PH_PING_DONE;
              end else if (num_kind == NK_COUNT) begin
                if ((!neg || acc == 0) && acc == 64'(eff_n) && eff_n == '0)
                  ph = PH_MT_DONE;
                else
                  ph = PH_BAD;
              end else begin
                if ((!neg || acc == 0) && acc <= 64'(ThrottleFull)) begin
                  wr_pend = cursor < CurW'(MAX_MOTORS);
                  ph = (cur1 >= eff_n) ? PH_MT_DONE : PH_BAD;
                end else begin
                  ph = PH_BAD;
                end
              end
            end
            parse_phase_next = PH_START;
            case (ph)
              PH_START, PH_HB, PH_INFO: ;
              PH_MT_DONE: begin
                set_cur_pend = 1'b1;
                standby_flag_next = 1'b0;
                want_frame = 1'b1;
              end
              PH_STAN: begin
                standby_flag_next = 1'b1;
                want_frame = 1'b1;
              end
              PH_FIN: begin
                run_mode_next = MODE_SHUT;
                clr_cur = 1'b1;
                want_frame = 1'b1;
              end
              PH_PING_DONE: begin
                if (neg) pv = 64'd0 - acc;
                else pv = (acc > Int64Top) ? Int64Top : acc;
                acc_next = pv;
                neg_next = 1'b0;
                want_pong = 1'b1;
              end
              default: begin
                run_mode_next = MODE_LAND;
                set_cur_safe = 1'b1;
                want_frame = 1'b1;
              end
            endcase
          end else begin
            line_length_next = line_length + LenW'(1);
            if (parse_phase == PH_NUM) begin
              if (digit) begin
                num_sub_next = SUB_DIGITS;
                if (acc > Div10Lim || (acc == Div10Lim && d > 64'd8))
                  acc_next = MagLimit;
                else
                  acc_next = (acc << 3) + (acc << 1) + d;
              end else begin
                done = 1'b0;
                if (num_sub == SUB_DIGITS) begin
                  if (num_kind == NK_PING) begin
                    parse_phase_next = PH_PING_DONE;
                    done = 1'b1;
                  end else if (num_kind == NK_COUNT) begin
                    if ((!neg || acc == 0) && acc == 64'(eff_n)) begin
                      cursor_next = '0;
                      if (eff_n == '0) begin
                        parse_phase_next = PH_MT_DONE;
                        done = 1'b1;
                      end else begin
                        num_kind_next = NK_VALUE;
                      end
                    end else begin
                      parse_phase_next = PH_BAD;
                      done = 1'b1;
                    end
                  end else begin
                    if ((!neg || acc == 0) && acc <= 64'(ThrottleFull)) begin
                      wr_pend = cursor < CurW'(MAX_MOTORS);
                      cursor_next = cur1;
                      if (cur1 >= eff_n) begin
                        parse_phase_next = PH_MT_DONE;
                        done = 1'b1;
                      end
                    end else begin
                      parse_phase_next = PH_BAD;
                      done = 1'b1;
                    end
                  end
                end
                if (!done) begin
                  if (num_sub == SUB_DIGITS) begin
                    acc_next = 64'd0;
                    neg_next = 1'b0;
                  end
                  if (num_sub != SUB_SIGN && is_blank(c)) begin
                    num_sub_next = SUB_SKIP;
                  end else if (num_sub != SUB_SIGN &&
                               (c == 8'h2B || c == 8'h2D)) begin
                    num_sub_next = SUB_SIGN;
                    neg_next = (c == 8'h2D);
                  end else begin
                    parse_phase_next = (num_kind == NK_PING) ? PH_PING_DONE : PH_BAD;
                  end
                end
              end
            end else if (parse_phase <= PH_INF) begin
              parse_phase_next = PH_BAD;
              if (parse_phase == PH_START && is_blank(c)) begin
                parse_phase_next = PH_START;
              end else if ((parse_phase == PH_M && c == 8'h74) ||
                           (parse_phase == PH_PIN && c == 8'h67)) begin
                parse_phase_next = PH_NUM;
                num_kind_next = (parse_phase == PH_M) ? NK_COUNT : NK_PING;
                num_sub_next = SUB_SKIP;
                acc_next = 64'd0;
                neg_next = 1'b0;
              end else begin
                case (parse_phase)
                  PH_START: begin
                    case (c)
                      8'h68: parse_phase_next = PH_H;
                      8'h6D: parse_phase_next = PH_M;
                      8'h73: parse_phase_next = PH_S;
                      8'h66: parse_phase_next = PH_F;
                      8'h6C: parse_phase_next = PH_L;
                      8'h70: parse_phase_next = PH_P;
                      8'h69: parse_phase_next = PH_I;
                      default: ;
                    endcase
                  end
                  PH_H:   if (c == 8'h62) parse_phase_next = PH_HB;
                  PH_S:   if (c == 8'h74) parse_phase_next = PH_ST;
                  PH_ST: begin
                    if (c == 8'h61) parse_phase_next = PH_STA;
                    else if (c == 8'h6F) parse_phase_next = PH_STO;
                  end
                  PH_STA: if (c == 8'h6E) parse_phase_next = PH_STAN;
                  PH_STO: if (c == 8'h70) parse_phase_next = PH_FIN;
                  PH_F:   if (c == 8'h69) parse_phase_next = PH_FI;
                  PH_FI:  if (c == 8'h6E) parse_phase_next = PH_FIN;
                  PH_L:   if (c == 8'h61) parse_phase_next = PH_LA;
                  PH_LA:  if (c == 8'h6E) parse_phase_next = PH_LAN;
                  PH_LAN: if (c == 8'h64) parse_phase_next = PH_LAND;
                  PH_P:   if (c == 8'h69) parse_phase_next = PH_PI;
                  PH_PI:  if (c == 8'h6E) parse_phase_next = PH_PIN;
                  PH_I:   if (c == 8'h6E) parse_phase_next = PH_IN;
                  PH_IN:  if (c == 8'h66) parse_phase_next = PH_INF;
                  PH_INF: if (c == 8'h6F) parse_phase_next = PH_INFO;
                  default: ;
                endcase
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      standby_flag <= 1'b1;
      run_mode     <= MODE_RUN;
      parse_phase  <= PH_START;
      num_sub      <= SUB_SKIP;
      num_kind     <= NK_COUNT;
      line_length  <= '0;
      idle_ticks   <= '0;
      acc          <= '0;
      neg          <= 1'b0;
      cursor       <= '0;
    end else if (cmd.accept) begin
      standby_flag <= standby_flag_next;
      run_mode     <= run_mode_next;
      parse_phase  <= parse_phase_next;
      num_sub      <= num_sub_next;
      num_kind     <= num_kind_next;
      line_length  <= line_length_next;
      idle_ticks   <= idle_ticks_next;
      acc          <= acc_next;
      neg          <= neg_next;
      cursor       <= cursor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_MOTORS; i++) begin
        pending[i] <= '0;
        current[i] <= '0;
      end
    end else if (cmd.accept) begin
      for (int i = 0; i < MAX_MOTORS; i++) begin
        if (clr_cur) begin
          current[i] <= '0;
        end else if (CurW'(i) < eff_n) begin
          if (set_cur_safe) current[i] <= safe_sat;
          else if (set_cur_pend) begin
            if (wr_pend && wr_pend_idx == IdxW'(i)) current[i] <= wr_pend_val;
            else current[i] <= pending[i];
          end
        end
      end
      if (wr_pend) pending[wr_pend_idx] <= wr_pend_val;
    end
  end

  // Frame walk counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      fidx <= '0;
    end else if (cmd.frame_start) begin
      fidx <= '0;
    end else if (cmd.frame_step) begin
      fidx <= fidx + IdxW'(1);
    end
  end

  assign stat.want_frame = want_frame && eff_n != '0;
  assign stat.want_pong  = want_pong;
  assign stat.frame_last = (CurW'(fidx) + CurW'(1)) == eff_n;
  assign stat.halted     = 1'b0;

  assign kind        = out_is_pong;
  assign motor_index = out_is_pong ? 3'd0 : 3'(fidx);
  assign throttle    = out_is_pong ? 10'd0 : current[fidx];
  assign last        = out_is_pong ? 1'b1 : stat.frame_last;
  assign pong_value  = out_is_pong ? acc : 64'd0;
  assign mode        = run_mode;
  assign standby     = standby_flag;
endmodule
`default_nettype wire

FILE: rtl/throttle_command_line_parser.sv
`default_nettype none
// Throttle command line parser.
// Input channel (in_valid/in_ready) carries one item per event: operation
// selects a received byte, a tick, a link fault or a link close, and
// byte_value holds the character for bytes. The configuration channel
// (cfg_valid/cfg_ready) writes motor_count, timeout_ticks and
// safe_land_throttle by index. The user must write them only while the
// block is idle; the block itself does not enforce it. Output channel
// (out_valid/out_ready) carries throttle frame entries, one per motor in
// motor order, or a single pong reply for a ping line. An item that
// produces results is parsed when taken, then the results leave one per
// cycle from the frame walker while the receiver is ready. Input is not
// taken while results are pending.
// When the receiver stalls, the current result holds on the outputs and
// the walker waits. Reset puts the block in standby and running mode with
// the parser at line start and all throttles at zero.
module throttle_command_line_parser #(
  parameter int MAX_MOTORS = tclp_pkg::MaxMotorsDef,
  parameter int LINE_LIMIT = tclp_pkg::LineLimitDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [7:0]  byte_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [2:0]       motor_index,
  output logic [9:0]       throttle,
  output logic             last,
  output logic [63:0]      pong_value,
  output logic [1:0]       mode,
  output logic             standby
);
  import tclp_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;
  logic      out_is_pong;

  assign cfg_ready = 1'b1;

  tclp_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .cmd, .out_is_pong
  );

  tclp_dp #(.MAX_MOTORS(MAX_MOTORS), .LINE_LIMIT(LINE_LIMIT)) u_dp (
    .clk, .rst, .operation, .byte_value, .cfg_valid, .cfg_index, .cfg_data,
    .cmd, .out_is_pong, .stat, .kind, .motor_index, .throttle, .last,
    .pong_value, .mode, .standby
  );
endmodule
`default_nettype wire
